// File: hw/rtl/ptlru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlru_pkg
// shared constants and types for the page table with lru frame list
// ----------------------------------------------------------------------------
package ptlru_pkg;

    localparam int PAGE_NUM_BITS    = 14;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int ADDR_BITS        = 26;
    localparam int FRAME_BITS       = 8;
    localparam int FRAME_COUNT      = 256;
    localparam int USED_BITS        = 9;
    localparam int PAGE_COUNT       = 1 << PAGE_NUM_BITS;

    typedef logic [PAGE_NUM_BITS-1:0] t_page;
    typedef logic [FRAME_BITS-1:0]    t_frame;

    localparam logic [2:0] REQ_LOOKUP = 3'd0;
    localparam logic [2:0] REQ_MAP    = 3'd1;
    localparam logic [2:0] REQ_DIRTY  = 3'd2;
    localparam logic [2:0] REQ_TAKE   = 3'd3;
    localparam logic [2:0] REQ_EVICT  = 3'd4;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [ADDR_BITS-1:0]  address;
        t_frame                frame;
    } t_req;

    typedef struct packed {
        logic        ok;
        t_frame      frame_out;
        logic        victim_dirty;
        logic [31:0] access_count;
        logic [31:0] fault_count;
        logic [31:0] dirty_evict_count;
    } t_rsp;

    // page table entry: frame, present, dirty
    typedef struct packed {
        t_frame frame;
        logic   present;
        logic   dirty;
    } t_pte;

endpackage

// File: hw/rtl/ptlru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlru_req_if / ptlru_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface ptlru_req_if;
    logic            valid;
    logic            ready;
    ptlru_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ptlru_rsp_if;
    logic            valid;
    logic            ready;
    ptlru_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/page_table_lru_frames_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_lru_frames_top
// page table of 2^14 entries with lru ordering of 256 physical frames
// ----------------------------------------------------------------------------
// usage:
//   i_req carries req_type, address and frame; o_rsp returns one result per
//   request (ok, frame_out, victim_dirty and the three running counts).
//   the page table sits in a one-port synchronous ram, the frame owner and
//   the lru next/prev links in small synchronous rams.
//   a request passes these states after its transfer, up to a valid result:
//   set dirty, take and unknown codes ST_RD, ST_OUT (read pte, then result);
//   lookup and map ST_RD, ST_LINK, ST_WB, ST_OUT (read pte, read links, write
//   back, relink); evict adds ST_OWN and ST_OPTE after ST_RD to reach the
//   owner's pte, unless the list is empty. one request is in flight at a time
//   and the next request transfers only after the result has been taken.
//   after reset the block sweeps the page table once, one entry a cycle,
//   with ready low; results are held in an output register so a stalled
//   receiver only blocks the next request's transfer.
// ----------------------------------------------------------------------------
module page_table_lru_frames_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptlru_req_if.sink         i_req,
    ptlru_rsp_if.source       o_rsp
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RD    = 8'b0000_0100,
        ST_OWN   = 8'b0000_1000,
        ST_OPTE  = 8'b0001_0000,
        ST_LINK  = 8'b0010_0000,
        ST_WB    = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // memories
    ptlru_pkg::t_pte pte_mem   [ptlru_pkg::PAGE_COUNT];
    ptlru_pkg::t_page own_mem  [ptlru_pkg::FRAME_COUNT];
    ptlru_pkg::t_frame nxt_mem [ptlru_pkg::FRAME_COUNT];
    ptlru_pkg::t_frame prv_mem [ptlru_pkg::FRAME_COUNT];

    logic                    pte_we;
    ptlru_pkg::t_page        pte_addr;
    ptlru_pkg::t_pte         pte_wd, r_pte_rd;
    logic                    own_we;
    ptlru_pkg::t_frame       own_addr;
    ptlru_pkg::t_page        r_own_rd;
    logic                    nxt_we, prv_we;
    ptlru_pkg::t_frame       nxt_waddr, prv_waddr, link_raddr;
    ptlru_pkg::t_frame       nxt_wd, prv_wd, r_nxt_rd, r_prv_rd;

    // request and control registers
    logic [2:0]              r_req;
    ptlru_pkg::t_page        r_page, r_clr;
    ptlru_pkg::t_frame       r_fr, r_f;
    ptlru_pkg::t_frame       r_head, r_tail;
    logic [ptlru_pkg::USED_BITS-1:0] r_used;
    logic [31:0]             r_acc, r_flt, r_dev;
    logic                    r_ok, r_vd, r_mv;
    logic                    r_ovalid;
    ptlru_pkg::t_rsp         r_rsp;

    always_ff @(posedge i_clk) begin
        if (pte_we) pte_mem[pte_addr] <= pte_wd;
        r_pte_rd <= pte_mem[pte_addr];
    end
    always_ff @(posedge i_clk) begin
        if (own_we) own_mem[own_addr] <= r_page;
        r_own_rd <= own_mem[own_addr];
    end
    always_ff @(posedge i_clk) begin
        if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wd;
        r_nxt_rd <= nxt_mem[link_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (prv_we) prv_mem[prv_waddr] <= prv_wd;
        r_prv_rd <= prv_mem[link_raddr];
    end

    ptlru_pkg::t_page req_page;
    assign req_page = i_req.payload.address[ptlru_pkg::PAGE_OFFSET_BITS +:
                                            ptlru_pkg::PAGE_NUM_BITS];

    logic acc;
    assign acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_rsp;

    // f moves to mru when r_mv is set, list has >1 entries and f is not head
    logic do_move;
    assign do_move = r_mv && (r_used > ptlru_pkg::USED_BITS'(1)) && (r_f != r_head);

    always_comb begin
        n_state   = r_state;
        pte_we    = 1'b0;
        pte_addr  = r_page;
        pte_wd    = r_pte_rd;
        own_we    = 1'b0;
        own_addr  = r_fr;
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        nxt_waddr = r_f;
        prv_waddr = r_head;
        nxt_wd    = r_head;
        prv_wd    = r_f;
        link_raddr = r_f;
        case (r_state)
            ST_CLEAR: begin
                pte_we   = 1'b1;
                pte_addr = r_clr;
                pte_wd   = '0;
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                pte_addr = req_page;
                own_addr = r_tail;
                if (acc) n_state = ST_RD;
            end
            ST_RD: begin
                // pte and tail owner data now valid
                case (r_req)
                    ptlru_pkg::REQ_LOOKUP: n_state = ST_LINK;
                    ptlru_pkg::REQ_MAP: begin
                        pte_we = 1'b1;
                        pte_wd = '{frame: r_fr, present: 1'b1, dirty: r_pte_rd.dirty};
                        own_we = ({1'b0, r_fr} < r_used);
                        n_state = ST_LINK;
                    end
                    ptlru_pkg::REQ_DIRTY: begin
                        pte_we = 1'b1;
                        pte_wd = '{frame: r_pte_rd.frame, present: r_pte_rd.present,
                                   dirty: 1'b1};
                        n_state = ST_OUT;
                    end
                    ptlru_pkg::REQ_EVICT: begin
                        // empty list: nothing to evict, straight to the result
                        pte_addr = r_own_rd;
                        n_state  = (r_used != '0) ? ST_OWN : ST_OUT;
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_OWN: begin
                pte_addr = r_page;
                n_state  = ST_OPTE;
            end
            ST_OPTE: begin
                // r_page holds owner here, pte data is the owner's entry
                pte_we = 1'b1;
                pte_wd = '{frame: r_pte_rd.frame, present: 1'b0, dirty: r_pte_rd.dirty};
                n_state = ST_LINK;
            end
            ST_LINK: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                // link data of r_f valid: prev p, next n
                if (do_move) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_prv_rd;
                    nxt_wd    = r_nxt_rd;
                    if (r_f != r_tail) begin
                        prv_we    = 1'b1;
                        prv_waddr = r_nxt_rd;
                        prv_wd    = r_prv_rd;
                    end
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // final relink of f at head
                if (do_move) begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_used   <= '0;
            r_acc    <= '0;
            r_flt    <= '0;
            r_dev    <= '0;
            r_ovalid <= 1'b0;
            r_mv     <= 1'b0;
            r_ok     <= 1'b0;
            r_vd     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_IDLE: begin
                    if (acc) begin
                        r_req <= i_req.payload.req_type;
                        r_page <= req_page;
                        r_fr  <= i_req.payload.frame;
                        r_ok  <= 1'b0;
                        r_vd  <= 1'b0;
                        r_mv  <= 1'b0;
                        r_f   <= '0;
                    end
                end
                ST_RD: begin
                    case (r_req)
                        ptlru_pkg::REQ_LOOKUP: begin
                            r_acc <= r_acc + 32'd1;
                            if (r_pte_rd.present) begin
                                r_ok <= 1'b1;
                                r_f  <= r_pte_rd.frame;
                                r_mv <= ({1'b0, r_pte_rd.frame} < r_used);
                            end else begin
                                r_flt <= r_flt + 32'd1;
                            end
                        end
                        ptlru_pkg::REQ_MAP: begin
                            r_f  <= r_fr;
                            r_mv <= ({1'b0, r_fr} < r_used);
                        end
                        ptlru_pkg::REQ_TAKE: begin
                            if (r_used < ptlru_pkg::USED_BITS'(ptlru_pkg::FRAME_COUNT)) begin
                                r_ok <= 1'b1;
                                r_f  <= r_used[ptlru_pkg::FRAME_BITS-1:0];
                                r_mv <= (r_used != '0);
                                if (r_used == '0) begin
                                    r_head <= '0;
                                    r_tail <= '0;
                                end
                                r_used <= r_used + 1'b1;
                            end
                        end
                        ptlru_pkg::REQ_EVICT: begin
                            if (r_used != '0) begin
                                r_ok   <= 1'b1;
                                r_f    <= r_tail;
                                r_mv   <= 1'b1;
                                r_page <= r_own_rd;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_OPTE: begin
                    if (r_pte_rd.dirty) begin
                        r_vd  <= 1'b1;
                        r_dev <= r_dev + 32'd1;
                    end
                end
                ST_WB: begin
                    if (do_move && r_f == r_tail) r_tail <= r_prv_rd;
                end
                ST_OUT: begin
                    if (do_move) r_head <= r_f;
                    r_ovalid <= 1'b1;
                    r_rsp <= '{ok: r_ok, frame_out: r_ok ? r_f : '0,
                               victim_dirty: r_vd, access_count: r_acc,
                               fault_count: r_flt, dirty_evict_count: r_dev};
                end
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/ptlru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlru_checker
// port-level checks of the request and result channels
// ----------------------------------------------------------------------------
module ptlru_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input ptlru_pkg::t_rsp i_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result changed while stalled");

    a_no_accept_with_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request taken while result pending");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken in flight");

    a_dirty_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.victim_dirty |-> i_rsp.ok)
        else $error("dirty victim without eviction");

endmodule

bind page_table_lru_frames_top ptlru_checker u_ptlru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

// File: bench/tb_page_table_lru_frames_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_table_lru_frames_top
// self-checking bench for the page table with lru frame replacement
// ----------------------------------------------------------------------------
// a scoreboard keeps its own page table, owner table and lru list, predicts
// one result per accepted request and compares results in order. a short
// directed run covers the corner cases, then random requests over a small
// page pool drive the table through frame exhaustion and many evictions,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_page_table_lru_frames_top;

    // request codes the block must ignore
    localparam logic [2:0] REQ_RSVD_A = 3'd5;
    localparam logic [2:0] REQ_RSVD_B = 3'd6;
    localparam logic [2:0] REQ_RSVD_C = 3'd7;
    localparam int RANDOM_ITEMS = 1900;
    localparam int POOL_PAGES   = 40;

    // scoreboard: mirror of the page table, owners and lru order
    class pt_scoreboard;
        ptlru_pkg::t_frame pte_frame [ptlru_pkg::PAGE_COUNT];
        bit                pte_present [ptlru_pkg::PAGE_COUNT];
        bit                pte_dirty [ptlru_pkg::PAGE_COUNT];
        ptlru_pkg::t_page  owner [ptlru_pkg::FRAME_COUNT];
        bit                owned [ptlru_pkg::FRAME_COUNT];
        ptlru_pkg::t_frame nxt [ptlru_pkg::FRAME_COUNT];
        ptlru_pkg::t_frame prv [ptlru_pkg::FRAME_COUNT];
        ptlru_pkg::t_frame head, tail;
        int                used;
        logic [31:0]       accesses, faults, dirty_evicts;
        ptlru_pkg::t_rsp   pending [$];
        int                errors, checked, hits, evicts;

        function new();
            foreach (pte_frame[i]) begin
                pte_frame[i] = '0;
                pte_present[i] = 0;
                pte_dirty[i] = 0;
            end
            foreach (owned[i]) begin
                owned[i] = 0;
                owner[i] = '0;
                nxt[i] = '0;
                prv[i] = '0;
            end
            head = '0;
            tail = '0;
            used = 0;
            accesses = '0;
            faults = '0;
            dirty_evicts = '0;
            errors = 0;
            checked = 0;
            hits = 0;
            evicts = 0;
        endfunction

        function void to_front(ptlru_pkg::t_frame f);
            ptlru_pkg::t_frame p, n;
            if (used <= 1 || f == head) return;
            p = prv[f];
            n = nxt[f];
            if (f == tail) tail = p;
            else prv[n] = p;
            nxt[p] = n;
            nxt[f] = head;
            prv[head] = f;
            head = f;
        endfunction

        // apply one accepted request and queue its result
        function void note_request(ptlru_pkg::t_req r);
            ptlru_pkg::t_rsp  e;
            ptlru_pkg::t_page pg;
            ptlru_pkg::t_page own;
            pg = r.address[ptlru_pkg::PAGE_OFFSET_BITS +: ptlru_pkg::PAGE_NUM_BITS];
            e = '0;
            case (r.req_type)
                ptlru_pkg::REQ_LOOKUP: begin
                    accesses++;
                    if (pte_present[pg]) begin
                        if (pte_frame[pg] < used) to_front(pte_frame[pg]);
                        e.ok = 1'b1;
                        e.frame_out = pte_frame[pg];
                        hits++;
                    end else begin
                        faults++;
                    end
                end
                ptlru_pkg::REQ_MAP: begin
                    pte_frame[pg] = r.frame;
                    pte_present[pg] = 1;
                    if (r.frame < used) begin
                        owner[r.frame] = pg;
                        owned[r.frame] = 1;
                        to_front(r.frame);
                    end
                end
                ptlru_pkg::REQ_DIRTY: pte_dirty[pg] = 1;
                ptlru_pkg::REQ_TAKE: begin
                    if (used < ptlru_pkg::FRAME_COUNT) begin
                        if (used == 0) begin
                            head = ptlru_pkg::t_frame'(used);
                            tail = ptlru_pkg::t_frame'(used);
                        end else begin
                            nxt[used] = head;
                            prv[head] = ptlru_pkg::t_frame'(used);
                            head = ptlru_pkg::t_frame'(used);
                        end
                        e.ok = 1'b1;
                        e.frame_out = ptlru_pkg::t_frame'(used);
                        used++;
                    end
                end
                ptlru_pkg::REQ_EVICT: begin
                    if (used != 0) begin
                        own = owner[tail];
                        if (pte_dirty[own]) begin
                            dirty_evicts++;
                            e.victim_dirty = 1'b1;
                        end
                        pte_present[own] = 0;
                        e.ok = 1'b1;
                        e.frame_out = tail;
                        to_front(tail);
                        evicts++;
                    end
                end
                default: ;
            endcase
            e.access_count = accesses;
            e.fault_count = faults;
            e.dirty_evict_count = dirty_evicts;
            pending.push_back(e);
        endfunction

        function void report(string name, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
        endfunction

        function void check_result(ptlru_pkg::t_rsp a);
            ptlru_pkg::t_rsp e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, a);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.ok !== e.ok) report("ok", e.ok, a.ok);
            if (a.frame_out !== e.frame_out) report("frame_out", e.frame_out, a.frame_out);
            if (a.victim_dirty !== e.victim_dirty)
                report("victim_dirty", e.victim_dirty, a.victim_dirty);
            if (a.access_count !== e.access_count)
                report("access_count", e.access_count, a.access_count);
            if (a.fault_count !== e.fault_count)
                report("fault_count", e.fault_count, a.fault_count);
            if (a.dirty_evict_count !== e.dirty_evict_count)
                report("dirty_evict_count", e.dirty_evict_count, a.dirty_evict_count);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ptlru_req_if req_if();
    ptlru_rsp_if rsp_if();
    pt_scoreboard sb;
    int  sent;
    int  long_hold_done;

    page_table_lru_frames_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // generous bound: reset sweep plus every item at worst gap and stall
    initial begin
        #4000000;
        $display("tb_page_table_lru_frames_top NOT OK");
        $finish;
    end

    // address of a page, with random offset bits
    function automatic logic [ptlru_pkg::ADDR_BITS-1:0] addr_of(ptlru_pkg::t_page pg);
        return {pg, ptlru_pkg::PAGE_OFFSET_BITS'($urandom)};
    endfunction

    function automatic ptlru_pkg::t_page pick_page();
        if ($urandom_range(0, 9) == 0) return ptlru_pkg::t_page'($urandom);
        if ($urandom_range(0, 19) == 0) return '1;
        return ptlru_pkg::t_page'($urandom_range(0, POOL_PAGES - 1));
    endfunction

    // one random request, shaped from the current scoreboard state
    function automatic ptlru_pkg::t_req make_request();
        ptlru_pkg::t_req r;
        int              sel;
        r.address = addr_of(pick_page());
        r.frame = ptlru_pkg::t_frame'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 35) r.req_type = ptlru_pkg::REQ_LOOKUP;
        else if (sel < 55) begin
            r.req_type = ptlru_pkg::REQ_MAP;
            // mostly map frames in use so that they gain owners
            if (sb.used > 0 && sel < 50)
                r.frame = ptlru_pkg::t_frame'($urandom_range(0, sb.used - 1));
        end
        else if (sel < 63) r.req_type = ptlru_pkg::REQ_DIRTY;
        else if (sel < 80) r.req_type = ptlru_pkg::REQ_TAKE;
        else if (sel < 97) r.req_type = ptlru_pkg::REQ_EVICT;
        else r.req_type = 3'($urandom_range(REQ_RSVD_A, REQ_RSVD_C));
        // an evict must never reach a frame whose owner was never set:
        // give the lru frame an owner instead
        if (r.req_type == ptlru_pkg::REQ_EVICT && sb.used > 0 && !sb.owned[sb.tail]) begin
            r.req_type = ptlru_pkg::REQ_MAP;
            r.frame = sb.tail;
        end
        return r;
    endfunction

    // offer one request after a random gap, wait for its transfer
    task automatic send_request(ptlru_pkg::t_req r, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        sent++;
    endtask

    task automatic send_op(logic [2:0] op, ptlru_pkg::t_page pg, ptlru_pkg::t_frame f);
        ptlru_pkg::t_req r;
        r.req_type = op;
        r.address = addr_of(pg);
        r.frame = f;
        send_request(r, 1'b0);
    endtask

    // result side: check every transfer, draw a stall after each one outside the no-stall windows
    initial begin : result_side
        int hold;
        hold = 0;
        long_hold_done = 0;
        rsp_if.ready = 1'b0;
        wait (sb != null);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result(rsp_if.payload);
                if (sb.checked == 500 && !long_hold_done) begin
                    // long hold so the block backs up into its input
                    hold = 300;
                    long_hold_done = 1;
                end else if ((sb.checked / 150) % 4 == 3) begin
                    hold = 0;
                end else begin
                    hold = $urandom_range(0, 5);
                end
            end
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        ptlru_pkg::t_req r;
        int              drain;
        sb = new();
        sent = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        send_op(ptlru_pkg::REQ_EVICT, 14'd0, 8'd0);    // evict with nothing in use
        send_op(ptlru_pkg::REQ_LOOKUP, 14'd0, 8'd0);   // fault
        r.req_type = ptlru_pkg::REQ_LOOKUP;
        r.address = '1;
        r.frame = '1;
        send_request(r, 1'b0);                         // all ones address, fault
        send_op(REQ_RSVD_A, 14'd3, 8'hff);
        send_op(REQ_RSVD_B, 14'd3, 8'h00);
        send_op(REQ_RSVD_C, '1, 8'h5a);
        send_op(ptlru_pkg::REQ_TAKE, 14'd0, 8'd0);     // frame 0
        send_op(ptlru_pkg::REQ_MAP, 14'd5, 8'd0);
        send_op(ptlru_pkg::REQ_EVICT, 14'd0, 8'd0);    // single frame, clean
        send_op(ptlru_pkg::REQ_LOOKUP, 14'd5, 8'd0);   // owner lost its mapping
        send_op(ptlru_pkg::REQ_MAP, 14'd5, 8'd0);
        send_op(ptlru_pkg::REQ_DIRTY, 14'd5, 8'hff);
        send_op(ptlru_pkg::REQ_EVICT, 14'd0, 8'd0);    // dirty victim
        send_op(ptlru_pkg::REQ_MAP, '1, 8'd255);       // frame not in use
        send_op(ptlru_pkg::REQ_LOOKUP, '1, 8'd0);      // hit on frame not in use
        send_op(ptlru_pkg::REQ_TAKE, 14'd0, 8'd0);     // frame 1
        send_op(ptlru_pkg::REQ_MAP, 14'd7, 8'd1);
        send_op(ptlru_pkg::REQ_LOOKUP, 14'd5, 8'd0);   // miss, page was evicted
        send_op(ptlru_pkg::REQ_MAP, 14'd5, 8'd0);
        send_op(ptlru_pkg::REQ_LOOKUP, 14'd5, 8'd0);   // hit, frame 0 to front
        send_op(ptlru_pkg::REQ_EVICT, 14'd0, 8'd0);    // two frames, tail taken

        // random traffic
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 1000) begin
                // sender pause until the block has drained
                req_if.valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            r = make_request();
            send_request(r, (i / 120) % 5 == 2);
        end
        req_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 20) begin
            @(posedge i_clk);
            drain++;
        end

        $display("run covered %0d requests, %0d results: %0d hits, %0d evictions",
                 sent, sb.checked, sb.hits, sb.evicts);
        $display("frames in use at end %0d, dirty evictions %0d",
                 sb.used, sb.dirty_evicts);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_page_table_lru_frames_top OK");
        end else begin
            $display("tb_page_table_lru_frames_top NOT OK");
        end
        $finish;
    end

endmodule

// File: page_table_lru_frames_top.f
hw/rtl/ptlru_pkg.sv
hw/rtl/ptlru_if.sv
hw/rtl/page_table_lru_frames_top.sv
hw/rtl/ptlru_checker.sv
bench/tb_page_table_lru_frames_top.sv
